// ===== rtl/pqls_pkg.sv =====
// ----------------------------------------------------------------------------
// pqls_pkg: shared types and codes of the linear scan priority queue
// Holds the request and response field widths, the command and status codes,
// and the packed layout of one stored queue entry.
// ----------------------------------------------------------------------------
package pqls_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // One stored pair. The priority member is called prio because
    // priority is a keyword of the language.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

endpackage

// ===== rtl/pqls_if.sv =====
// ----------------------------------------------------------------------------
// pqls_if: request and response channels of the priority queue
// Valid/ready channels; a request or response moves at a rising clock edge
// where valid and ready are both high.
// ----------------------------------------------------------------------------
interface pqls_req_if;

    logic                                valid;
    logic                                ready;
    logic [pqls_pkg::CMD_W-1:0]          command;
    logic signed [pqls_pkg::DATA_W-1:0]  item_value;
    logic signed [pqls_pkg::DATA_W-1:0]  item_priority;

    modport source (output valid, output command, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input command, input item_value,
                    input item_priority, output ready);

endinterface

interface pqls_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [pqls_pkg::STAT_W-1:0]         status;
    logic signed [pqls_pkg::DATA_W-1:0]  head_value;
    logic signed [pqls_pkg::DATA_W-1:0]  head_priority;
    logic [pqls_pkg::OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output head_value,
                    output head_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input head_value,
                    input head_priority, input occupancy, output ready);

endinterface

// ===== rtl/pqls_mem.sv =====
// ----------------------------------------------------------------------------
// pqls_mem: entry storage of the priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pqls_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  pqls_pkg::entry_t        wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output pqls_pkg::entry_t        rd_data
);

    pqls_pkg::entry_t mem [DEPTH];
    pqls_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pqls_best.sv =====
// ----------------------------------------------------------------------------
// pqls_best: running winner of the head scan
// Compares each entry read from storage against the best one so far and
// keeps the winner and its index.
// ----------------------------------------------------------------------------
module pqls_best #(
    parameter int IDX_W = 7
) (
    input  logic                    clk,
    input  logic                    upd,
    input  logic                    first,
    input  logic [IDX_W-1:0]        idx,
    input  pqls_pkg::entry_t        cand,
    output pqls_pkg::entry_t        best,
    output logic [IDX_W-1:0]        best_idx
);

    pqls_pkg::entry_t   best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               wins;

    // Strictly better only, so the earliest entry survives a full tie.
    assign wins = (cand.prio > best_reg.prio) ||
                  ((cand.prio == best_reg.prio) && (cand.value > best_reg.value));

    always_ff @(posedge clk)
    begin
        if (upd && (first || wins))
        begin
            best_reg     <= cand;
            best_idx_reg <= idx;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== rtl/priority_queue_linear_scan_top.sv =====
// ----------------------------------------------------------------------------
// priority_queue_linear_scan_top: unsorted array priority queue
// Enqueue appends a pair, peek finds the highest priority entry by a linear
// scan, and dequeue also removes it by shifting the later entries down.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH (value, priority) pairs in a single-port
// read, single-port write memory in arrival order, and each request returns
// exactly one response. A peek reads every held entry through the one read
// port into a shared compare unit. A dequeue runs the same scan and then
// copies each entry behind the winner one place down through the same read
// port and the write port. One entry moves through the read port per cycle.
// The block accepts one request at a time and raises ready again once the
// response has been handed to the output register, which may still be
// waiting on the downstream side. Requests with an empty queue, a full queue
// or an unused command code go straight to the response state without a
// scan.
// Highest priority wins, then the larger value, then the earliest entry.
module priority_queue_linear_scan_top #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    pqls_req_if.sink    req,
    pqls_rsp_if.source  rsp
);

    // Index width for the memory and count width that can hold QUEUE_DEPTH.
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [pqls_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic                           rd_vld_reg;
    logic [AW-1:0]                  rd_idx_reg;
    logic [pqls_pkg::STAT_W-1:0]    res_status_reg, res_status_next;
    logic                           res_head_reg, res_head_next;

    // Output register of the response channel.
    logic                               rsp_valid_reg;
    logic [pqls_pkg::STAT_W-1:0]        rsp_status_reg;
    logic signed [pqls_pkg::DATA_W-1:0] rsp_value_reg;
    logic signed [pqls_pkg::DATA_W-1:0] rsp_prio_reg;
    logic [pqls_pkg::OCC_W-1:0]         rsp_occ_reg;
    logic                               rsp_load;

    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    pqls_pkg::entry_t       mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    pqls_pkg::entry_t       mem_rd_data;

    logic                   best_upd;
    pqls_pkg::entry_t       best;
    logic [AW-1:0]          best_idx;

    logic [CW+pqls_pkg::OCC_W-1:0] count_ext;

    pqls_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The first entry read in a scan always loads the compare unit, so a
    // queue holding only the lowest priority still selects an entry.
    pqls_best #(
        .IDX_W (AW)
    ) u_best (
        .clk      (clk),
        .upd      (best_upd),
        .first    (rd_idx_reg == '0),
        .idx      (rd_idx_reg),
        .cand     (mem_rd_data),
        .best     (best),
        .best_idx (best_idx)
    );

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg[AW-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = count_reg[AW-1:0];
        mem_wr_data     = '{value: req.item_value, prio: req.item_priority};
        best_upd        = 1'b0;
        rsp_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = req.command;
                    res_status_next = pqls_pkg::ST_OK;
                    res_head_next   = 1'b0;
                    state_next      = S_RESP;
                    unique case (req.command) inside
                        pqls_pkg::CMD_ENQUEUE:
                        begin
                            if (count_reg < CW'(QUEUE_DEPTH))
                            begin
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                res_status_next = pqls_pkg::ST_FULL;
                            end
                        end
                        pqls_pkg::CMD_DEQUEUE, pqls_pkg::CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = pqls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused command: answer OK and change nothing.
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads are issued one per cycle; each result reaches the
                // compare unit in the cycle after its read.
                best_upd = rd_vld_reg;
                if (idx_reg < count_reg)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    res_head_next = 1'b1;
                    if (cmd_reg == pqls_pkg::CMD_DEQUEUE)
                    begin
                        idx_next   = CW'(best_idx) + CW'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_SHIFT:
            begin
                // Entry i+1 is read, then written back to place i.
                if (idx_reg < count_reg)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = rd_idx_reg - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if ((idx_reg >= count_reg) && !rd_vld_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= mem_rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        res_status_reg <= res_status_next;
        res_head_reg   <= res_head_next;
        rd_idx_reg     <= mem_rd_addr;
    end

    // The occupancy field carries the low bits of the count.
    assign count_ext = {{pqls_pkg::OCC_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_value_reg  <= res_head_reg ? best.value : '0;
            rsp_prio_reg   <= res_head_reg ? best.prio : '0;
            rsp_occ_reg    <= count_ext[pqls_pkg::OCC_W-1:0];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.head_value    = rsp_value_reg;
    assign rsp.head_priority = rsp_prio_reg;
    assign rsp.occupancy     = rsp_occ_reg;

endmodule

// ===== rtl/pqls_chk.sv =====
// ----------------------------------------------------------------------------
// pqls_chk: port checks of the priority queue
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module pqls_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic [pqls_pkg::STAT_W-1:0]          rsp_status,
    input logic signed [pqls_pkg::DATA_W-1:0]   rsp_head_value,
    input logic signed [pqls_pkg::DATA_W-1:0]   rsp_head_priority,
    input logic [pqls_pkg::OCC_W-1:0]           rsp_occupancy
);

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_head_value) &&
             $stable(rsp_head_priority) && $stable(rsp_occupancy)))
        else $error("response changed while stalled");

    // The queue works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    // A failed request carries no head entry.
    a_fail_no_head: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != pqls_pkg::ST_OK)) |->
            ((rsp_head_value == '0) && (rsp_head_priority == '0)))
        else $error("head reported on a failed request");

    // An empty report can only come from an empty queue.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == pqls_pkg::ST_EMPTY)) |->
            (rsp_occupancy == '0))
        else $error("empty status with entries held");

endmodule

bind priority_queue_linear_scan_top pqls_chk u_pqls_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_head_value    (rsp.head_value),
    .rsp_head_priority (rsp.head_priority),
    .rsp_occupancy     (rsp.occupancy)
);
